/* rtl/lpmd_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants of the length-prefixed message deframer
package lpmd_pkg;

  // default header size in bytes
  localparam int HEADER_LEN_DEF = 10;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // reset values of the registers
  localparam logic [7:0]  SYNC_RST = 8'd0;
  localparam logic [30:0] MAX_RST  = 31'd1048576;

  // register indexes as seen on paddr[2]
  localparam logic REG_SYNC = 1'b0;
  localparam logic REG_MAX  = 1'b1;

  // header byte offsets
  localparam int OFS_SYNC = 0;
  localparam int OFS_LEN  = 2;

  // one result request
  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       fin;
    logic       err;
  } res_t;

  // front sequencer states
  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_CHECK,
    ST_RELEASE
  } front_state_t;

endpackage

/* rtl/lpmd_front.sv */
`timescale 1ns / 1ps
// front part: gathers the header, checks it and queues result requests
module lpmd_front #(
  parameter int HEADER_LEN = lpmd_pkg::HEADER_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_byte,
  input  logic              in_chunk_end,
  input  logic [7:0]        sync_byte,
  input  logic [30:0]       max_length,
  output logic              push,
  output lpmd_pkg::res_t    push_entry,
  input  logic              q_full
);
  import lpmd_pkg::*;

  localparam int CW = $clog2(HEADER_LEN);

  front_state_t  state_r, state_nxt;
  logic [7:0]    store_r [HEADER_LEN];
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [30:0]   remain_r, remain_nxt;
  logic          in_payload_r, in_payload_nxt;
  logic          discard_r, discard_nxt;
  logic          last_r, last_nxt;

  logic          accept;
  logic          hdr_done;
  logic          idx_last;
  logic          pay_end;
  logic [31:0]   len;
  logic          bad;
  logic [31:0]   len_less;

  assign accept   = in_valid && !in_stall;
  assign hdr_done = (fill_r == CW'(HEADER_LEN - 1));
  assign idx_last = (idx_r == CW'(HEADER_LEN - 1));
  assign pay_end  = (remain_r <= 31'd1);

  // length field, little endian
  assign len = {store_r[OFS_LEN + 3], store_r[OFS_LEN + 2],
                store_r[OFS_LEN + 1], store_r[OFS_LEN]};
  assign len_less = len - 32'(HEADER_LEN);

  // header check
  assign bad = (store_r[OFS_SYNC] != sync_byte) || len[31] ||
               (len < 32'(HEADER_LEN)) || (len[30:0] > max_length);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_COLLECT: begin
        if (accept && !discard_r && !in_payload_r && hdr_done) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!bad) begin
          state_nxt = ST_RELEASE;
        end else if (!q_full) begin
          state_nxt = ST_COLLECT;
        end
      end
      ST_RELEASE: begin
        if (!q_full && idx_last) begin
          state_nxt = ST_COLLECT;
        end
      end
      default: state_nxt = ST_COLLECT;
    endcase
  end

  // outputs
  always_comb begin
    push       = 1'b0;
    push_entry = '0;
    in_stall   = 1'b1;
    case (state_r)
      ST_COLLECT: begin
        in_stall         = q_full;
        push             = accept && !discard_r && in_payload_r;
        push_entry.data  = in_byte;
        push_entry.fin   = pay_end;
      end
      ST_CHECK: begin
        push           = bad && !q_full;
        push_entry.err = 1'b1;
      end
      ST_RELEASE: begin
        push             = !q_full;
        push_entry.data  = store_r[idx_r];
        push_entry.start = (idx_r == '0);
        push_entry.fin   = idx_last && !in_payload_r;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  // datapath next values
  always_comb begin
    fill_nxt       = fill_r;
    idx_nxt        = idx_r;
    remain_nxt     = remain_r;
    in_payload_nxt = in_payload_r;
    discard_nxt    = discard_r;
    last_nxt       = last_r;
    case (state_r)
      ST_COLLECT: begin
        if (accept) begin
          if (discard_r) begin
            if (in_chunk_end) begin
              discard_nxt = 1'b0;
            end
          end else if (in_payload_r) begin
            remain_nxt     = pay_end ? 31'd0 : remain_r - 31'd1;
            in_payload_nxt = !pay_end;
          end else if (hdr_done) begin
            fill_nxt = '0;
            last_nxt = in_chunk_end;
          end else begin
            fill_nxt = fill_r + CW'(1);
          end
        end
      end
      ST_CHECK: begin
        idx_nxt = '0;
        if (bad) begin
          if (!q_full) begin
            discard_nxt = !last_r;
          end
        end else begin
          remain_nxt     = len_less[30:0];
          in_payload_nxt = (len_less[30:0] != 31'd0);
        end
      end
      ST_RELEASE: begin
        if (!q_full) begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      default: begin
        idx_nxt = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_COLLECT;
      fill_r       <= '0;
      idx_r        <= '0;
      remain_r     <= '0;
      in_payload_r <= 1'b0;
      discard_r    <= 1'b0;
      last_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      idx_r        <= idx_nxt;
      remain_r     <= remain_nxt;
      in_payload_r <= in_payload_nxt;
      discard_r    <= discard_nxt;
      last_r       <= last_nxt;
    end
  end

  // header byte store
  always_ff @(posedge clk) begin
    if (state_r == ST_COLLECT && accept && !discard_r && !in_payload_r) begin
      store_r[fill_r] <= in_byte;
    end
  end

endmodule

/* rtl/lpmd_queue.sv */
`timescale 1ns / 1ps
// short request queue between front and back
module lpmd_queue #(
  parameter int DEPTH = lpmd_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lpmd_pkg::res_t push_entry,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output lpmd_pkg::res_t head
);
  import lpmd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  res_t          mem_r [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt;
  logic [PW-1:0] rd_r, rd_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == NW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_r];

  // pointer and count update
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + NW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_entry;
    end
  end

endmodule

/* rtl/lpmd_back.sv */
`timescale 1ns / 1ps
// back part: takes requests from the queue into the result register
module lpmd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           not_empty,
  input  lpmd_pkg::res_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_byte,
  output logic           out_msg_start,
  output logic           out_msg_end,
  output logic           out_header_error
);
  import lpmd_pkg::*;

  logic out_valid_r, out_valid_nxt;
  res_t res_r;

  // load when the register is empty or being taken
  assign pop           = not_empty && (!out_valid_r || !out_stall);
  assign out_valid_nxt = pop || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= head;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = res_r.data;
  assign out_msg_start    = res_r.start;
  assign out_msg_end      = res_r.fin;
  assign out_header_error = res_r.err;

endmodule

/* rtl/length_prefixed_message_deframer_unit.sv */
`timescale 1ns / 1ps
// top level of the length-prefixed message deframer
//
// Input channel (in_valid / in_stall): one received byte per request, with
// in_chunk_end on the last byte of a chunk. Result channel (out_valid /
// out_stall): message bytes with out_msg_start on the first byte and
// out_msg_end on the last, or one request with out_header_error set and a
// zero byte when a header fails the sync or length check.
// Registers over APB: sync_byte at 0x0, max_length at 0x4.
// Header bytes are taken one per cycle while the queue is not full,
// without results. After the last header byte the front checks the header
// in ST_CHECK, then releases a good header's bytes one per cycle while the
// queue is not full, with the input stalled. Payload bytes pass at one per
// cycle while the queue is not full, via the queue and the result register.
// The front queues requests in a QUEUE_DEPTH-entry queue; the back loads
// them into the result register. When the receiver stalls, the result
// holds, the queue fills and then in_stall rises.
// Synchronous reset clears all control state and the registers to their
// defaults (sync_byte 0, max_length 1048576).
module length_prefixed_message_deframer_unit #(
  parameter int HEADER_LEN = lpmd_pkg::HEADER_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_chunk_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_msg_start,
  output logic        out_msg_end,
  output logic        out_header_error,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lpmd_pkg::*;

  logic [7:0]  sync_r;
  logic [30:0] max_r;
  logic        wr_en;
  logic        push;
  res_t        push_entry;
  logic        q_full;
  logic        pop;
  logic        not_empty;
  res_t        head;

  // register port
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r <= SYNC_RST;
      max_r  <= MAX_RST;
    end else if (wr_en) begin
      if (paddr[2] == REG_SYNC) begin
        sync_r <= pwdata[7:0];
      end else begin
        max_r <= pwdata[30:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_MAX) ? {1'b0, max_r} : {24'd0, sync_r};

  lpmd_front #(
    .HEADER_LEN(HEADER_LEN)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .in_chunk_end(in_chunk_end),
    .sync_byte   (sync_r),
    .max_length  (max_r),
    .push        (push),
    .push_entry  (push_entry),
    .q_full      (q_full)
  );

  lpmd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .full      (q_full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  lpmd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .not_empty       (not_empty),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_msg_start   (out_msg_start),
    .out_msg_end     (out_msg_end),
    .out_header_error(out_header_error)
  );

endmodule

/* rtl/lpmd_checker.sv */
`timescale 1ns / 1ps
// port checks of the deframer, bound to the top level
module lpmd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_msg_start,
  input logic       out_msg_end,
  input logic       out_header_error
);

  // a stalled result stays and holds its fields
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) &&
      $stable(out_msg_start) && $stable(out_msg_end) && $stable(out_header_error))
    else $error("stalled result changed");

  // an error request carries a zero byte and no message marks
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_header_error |-> out_byte == 8'd0 && !out_msg_start && !out_msg_end)
    else $error("malformed error result");

  // nothing is offered right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind length_prefixed_message_deframer_unit lpmd_checker u_chk (.*);
